[rtl/core/vgar_pkg.sv]
// Shared types, port codes and sizes for the VGA register and DAC port block.
package vgar_pkg;

    // Default bank and palette sizes.
    localparam int CRT_REG_COUNT_DEF   = 32;
    localparam int GFX_REG_COUNT_DEF   = 8;
    localparam int SEQ_REG_COUNT_DEF   = 8;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Depth of the command queue between decode and execution.
    localparam int QUEUE_DEPTH = 2;

    // Access kinds.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Implemented I/O ports.
    localparam logic [9:0] PORT_SEQ_IDX  = 10'h3c4;
    localparam logic [9:0] PORT_SEQ_DAT  = 10'h3c5;
    localparam logic [9:0] PORT_MASK     = 10'h3c6;
    localparam logic [9:0] PORT_PAL_RIDX = 10'h3c7;
    localparam logic [9:0] PORT_PAL_WIDX = 10'h3c8;
    localparam logic [9:0] PORT_PAL_DAT  = 10'h3c9;
    localparam logic [9:0] PORT_GFX_IDX  = 10'h3ce;
    localparam logic [9:0] PORT_GFX_DAT  = 10'h3cf;
    localparam logic [9:0] PORT_CRT_IDX  = 10'h3d4;
    localparam logic [9:0] PORT_CRT_DAT  = 10'h3d5;

    // The hidden DAC register is reached after this many mask reads in a row.
    localparam logic [2:0] MASK_ARM_COUNT = 3'd4;

    // Palette color components.
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // Port class produced by the decoder.
    typedef enum logic [3:0] {
        PC_NONE,
        PC_SEQ_IDX,
        PC_SEQ_DAT,
        PC_GFX_IDX,
        PC_GFX_DAT,
        PC_CRT_IDX,
        PC_CRT_DAT,
        PC_MASK,
        PC_PAL_RIDX,
        PC_PAL_WIDX,
        PC_PAL_DAT
    } port_class_t;

    // One decoded access as it waits in the queue.
    typedef struct packed {
        logic        op;
        port_class_t pclass;
        logic [7:0]  write_data;
    } cmd_t;

    // Write strobes for one index/data bank.
    typedef struct packed {
        logic idx_we;
        logic dat_we;
    } bank_ctl_t;

    // Execution unit states.
    typedef enum logic {
        BK_IDLE,
        BK_PAL_READ
    } back_state_t;

endpackage

[rtl/core/vgar_req_if.sv]
// Request channel carrying one I/O access.
interface vgar_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [9:0] port_address;
    logic [7:0] write_data;

    modport source (output valid, output op, output port_address, output write_data,
                    input ready);
    modport sink (input valid, input op, input port_address, input write_data,
                  output ready);
endinterface

[rtl/core/vgar_rsp_if.sv]
// Response channel carrying the result of one I/O access.
interface vgar_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       port_decoded;

    modport source (output valid, output read_data, output port_decoded, input ready);
    modport sink (input valid, input read_data, input port_decoded, output ready);
endinterface

[rtl/core/vgar_front.sv]
// Front end: accepts accesses, classifies the port address and feeds the queue.
module vgar_front (
    vgar_req_if.sink        req,
    output logic            push_valid,
    output vgar_pkg::cmd_t  push_cmd,
    input  logic            push_ready
);

    vgar_pkg::port_class_t pclass;

    // Map the port address onto the class of register it reaches.
    always_comb
    begin
        unique case (req.port_address)
            vgar_pkg::PORT_SEQ_IDX:  pclass = vgar_pkg::PC_SEQ_IDX;
            vgar_pkg::PORT_SEQ_DAT:  pclass = vgar_pkg::PC_SEQ_DAT;
            vgar_pkg::PORT_GFX_IDX:  pclass = vgar_pkg::PC_GFX_IDX;
            vgar_pkg::PORT_GFX_DAT:  pclass = vgar_pkg::PC_GFX_DAT;
            vgar_pkg::PORT_CRT_IDX:  pclass = vgar_pkg::PC_CRT_IDX;
            vgar_pkg::PORT_CRT_DAT:  pclass = vgar_pkg::PC_CRT_DAT;
            vgar_pkg::PORT_MASK:     pclass = vgar_pkg::PC_MASK;
            vgar_pkg::PORT_PAL_RIDX: pclass = vgar_pkg::PC_PAL_RIDX;
            vgar_pkg::PORT_PAL_WIDX: pclass = vgar_pkg::PC_PAL_WIDX;
            vgar_pkg::PORT_PAL_DAT:  pclass = vgar_pkg::PC_PAL_DAT;
            default:                 pclass = vgar_pkg::PC_NONE;
        endcase
    end

    // A transfer happens whenever a request is valid and the queue has room.
    assign push_valid          = req.valid;
    assign req.ready           = push_ready;
    assign push_cmd.op         = req.op;
    assign push_cmd.pclass     = pclass;
    assign push_cmd.write_data = req.write_data;

endmodule

[rtl/core/vgar_queue.sv]
// Short FIFO of decoded commands between the front end and the execution unit.
module vgar_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  vgar_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    output logic            pop_valid,
    output vgar_pkg::cmd_t  pop_cmd,
    input  logic            pop_ready
);

    localparam int PW = (vgar_pkg::QUEUE_DEPTH > 1) ? $clog2(vgar_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(vgar_pkg::QUEUE_DEPTH + 1);

    vgar_pkg::cmd_t entries_reg [vgar_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(vgar_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(vgar_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(vgar_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/vgar_bank.sv]
// One index/data register bank: an index register and its data registers.
module vgar_bank #(
    parameter int COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vgar_pkg::bank_ctl_t   ctl,
    input  logic [7:0]            wdata,
    output logic [7:0]            index,
    output logic [7:0]            data
);

    localparam int IW = (COUNT > 1) ? $clog2(COUNT) : 1;

    logic [7:0] index_reg;
    logic [7:0] regs_reg [COUNT];
    logic       in_range;

    // Indexes at or beyond the bank size ignore writes and read as zero.
    assign in_range = ({1'b0, index_reg} < 9'(COUNT));
    assign index    = index_reg;
    assign data     = in_range ? regs_reg[index_reg[IW-1:0]] : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= 8'h00;
            for (int i = 0; i < COUNT; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (ctl.idx_we)
            begin
                index_reg <= wdata;
            end
            if (ctl.dat_we && in_range)
            begin
                regs_reg[index_reg[IW-1:0]] <= wdata;
            end
        end
    end

endmodule

[rtl/core/vgar_back.sv]
// Execution unit: register banks, pixel mask, hidden DAC and palette DAC.
module vgar_back #(
    parameter int CRT_REG_COUNT   = vgar_pkg::CRT_REG_COUNT_DEF,
    parameter int GFX_REG_COUNT   = vgar_pkg::GFX_REG_COUNT_DEF,
    parameter int SEQ_REG_COUNT   = vgar_pkg::SEQ_REG_COUNT_DEF,
    parameter int PALETTE_ENTRIES = vgar_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  vgar_pkg::cmd_t  cmd,
    output logic            cmd_ready,
    vgar_rsp_if.source      rsp
);

    localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    vgar_pkg::back_state_t state_reg, state_next;

    // Scalar DAC state.
    logic [7:0]  pixel_mask_reg, pixel_mask_next;
    logic [7:0]  aux_dac_reg, aux_dac_next;
    logic [2:0]  mask_count_reg, mask_count_next;
    logic [7:0]  pal_ridx_reg, pal_ridx_next;
    logic [7:0]  pal_widx_reg, pal_widx_next;
    logic [1:0]  rcomp_reg, rcomp_next;
    logic [1:0]  wcomp_reg, wcomp_next;
    logic [15:0] color_latch_reg, color_latch_next;

    // Palette memory with per-entry valid bits.
    logic [23:0] pal_mem [PALETTE_ENTRIES];
    logic        pal_valid_reg [PALETTE_ENTRIES];
    logic [23:0] pal_rdata_reg;
    logic        pal_hit_reg;
    logic        pal_we;
    logic [23:0] pal_wdata;
    logic        pal_rd_in_range, pal_wr_in_range;
    logic [23:0] pal_entry;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;
    logic        out_decoded_reg;
    logic        res_load;
    logic [7:0]  res_data;
    logic        res_decoded;

    // Bank connections.
    vgar_pkg::bank_ctl_t seq_ctl, gfx_ctl, crt_ctl;
    logic [7:0] seq_index, gfx_index, crt_index;
    logic [7:0] seq_data, gfx_data, crt_data;

    logic pop;
    logic is_rd;

    vgar_bank #(.COUNT(SEQ_REG_COUNT)) u_seq (
        .clk(clk), .rst_n(rst_n), .ctl(seq_ctl), .wdata(cmd.write_data),
        .index(seq_index), .data(seq_data)
    );
    vgar_bank #(.COUNT(GFX_REG_COUNT)) u_gfx (
        .clk(clk), .rst_n(rst_n), .ctl(gfx_ctl), .wdata(cmd.write_data),
        .index(gfx_index), .data(gfx_data)
    );
    vgar_bank #(.COUNT(CRT_REG_COUNT)) u_crt (
        .clk(clk), .rst_n(rst_n), .ctl(crt_ctl), .wdata(cmd.write_data),
        .index(crt_index), .data(crt_data)
    );

    // A command is taken only when idle and the result register will be free.
    assign pop       = (state_reg == vgar_pkg::BK_IDLE) && cmd_valid
                       && (!out_valid_reg || rsp.ready);
    assign cmd_ready = pop;
    assign is_rd     = (cmd.op == vgar_pkg::OP_READ);

    assign pal_rd_in_range = ({1'b0, pal_ridx_reg} < 9'(PALETTE_ENTRIES));
    assign pal_wr_in_range = ({1'b0, pal_widx_reg} < 9'(PALETTE_ENTRIES));
    assign pal_entry       = pal_hit_reg ? pal_rdata_reg : 24'h000000;
    assign pal_wdata       = {color_latch_reg, cmd.write_data};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vgar_pkg::BK_IDLE:
            begin
                if (pop && is_rd && (cmd.pclass == vgar_pkg::PC_PAL_DAT))
                begin
                    state_next = vgar_pkg::BK_PAL_READ;
                end
            end
            vgar_pkg::BK_PAL_READ:
            begin
                state_next = vgar_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = vgar_pkg::BK_IDLE;
            end
        endcase
    end

    // Command execution and result formation.
    always_comb
    begin
        pixel_mask_next  = pixel_mask_reg;
        aux_dac_next     = aux_dac_reg;
        mask_count_next  = mask_count_reg;
        pal_ridx_next    = pal_ridx_reg;
        pal_widx_next    = pal_widx_reg;
        rcomp_next       = rcomp_reg;
        wcomp_next       = wcomp_reg;
        color_latch_next = color_latch_reg;
        pal_we           = 1'b0;
        seq_ctl          = '0;
        gfx_ctl          = '0;
        crt_ctl          = '0;
        res_load         = 1'b0;
        res_data         = 8'h00;
        res_decoded      = 1'b1;

        unique case (state_reg)
            vgar_pkg::BK_IDLE:
            begin
                if (pop)
                begin
                    // Every port other than the mask breaks a run of mask reads.
                    if (cmd.pclass != vgar_pkg::PC_MASK)
                    begin
                        mask_count_next = 3'd0;
                    end
                    // Palette data reads finish once the memory has answered.
                    res_load = !(is_rd && (cmd.pclass == vgar_pkg::PC_PAL_DAT));
                    unique case (cmd.pclass)
                        vgar_pkg::PC_SEQ_IDX:
                        begin
                            if (is_rd) res_data = seq_index;
                            else       seq_ctl.idx_we = 1'b1;
                        end
                        vgar_pkg::PC_SEQ_DAT:
                        begin
                            if (is_rd) res_data = seq_data;
                            else       seq_ctl.dat_we = 1'b1;
                        end
                        vgar_pkg::PC_GFX_IDX:
                        begin
                            if (is_rd) res_data = gfx_index;
                            else       gfx_ctl.idx_we = 1'b1;
                        end
                        vgar_pkg::PC_GFX_DAT:
                        begin
                            if (is_rd) res_data = gfx_data;
                            else       gfx_ctl.dat_we = 1'b1;
                        end
                        vgar_pkg::PC_CRT_IDX:
                        begin
                            if (is_rd) res_data = crt_index;
                            else       crt_ctl.idx_we = 1'b1;
                        end
                        vgar_pkg::PC_CRT_DAT:
                        begin
                            if (is_rd) res_data = crt_data;
                            else       crt_ctl.dat_we = 1'b1;
                        end
                        vgar_pkg::PC_MASK:
                        begin
                            if (mask_count_reg >= vgar_pkg::MASK_ARM_COUNT)
                            begin
                                if (is_rd) res_data = aux_dac_reg;
                                else       aux_dac_next = cmd.write_data;
                                mask_count_next = 3'd0;
                            end
                            else if (is_rd)
                            begin
                                res_data        = pixel_mask_reg;
                                mask_count_next = mask_count_reg + 3'd1;
                            end
                            else
                            begin
                                pixel_mask_next = cmd.write_data;
                                mask_count_next = 3'd0;
                            end
                        end
                        vgar_pkg::PC_PAL_RIDX:
                        begin
                            if (!is_rd)
                            begin
                                pal_ridx_next = cmd.write_data;
                                rcomp_next    = vgar_pkg::COMP_RED;
                            end
                        end
                        vgar_pkg::PC_PAL_WIDX:
                        begin
                            if (is_rd)
                            begin
                                res_data = pal_widx_reg;
                            end
                            else
                            begin
                                pal_widx_next = cmd.write_data;
                                wcomp_next    = vgar_pkg::COMP_RED;
                            end
                        end
                        vgar_pkg::PC_PAL_DAT:
                        begin
                            if (!is_rd)
                            begin
                                if (wcomp_reg == vgar_pkg::COMP_RED)
                                begin
                                    color_latch_next[15:8] = cmd.write_data;
                                    wcomp_next             = vgar_pkg::COMP_GREEN;
                                end
                                else if (wcomp_reg == vgar_pkg::COMP_GREEN)
                                begin
                                    color_latch_next[7:0] = cmd.write_data;
                                    wcomp_next            = vgar_pkg::COMP_BLUE;
                                end
                                else
                                begin
                                    pal_we        = pal_wr_in_range;
                                    wcomp_next    = vgar_pkg::COMP_RED;
                                    pal_widx_next = pal_widx_reg + 8'd1;
                                end
                            end
                        end
                        default:
                        begin
                            res_decoded = 1'b0;
                        end
                    endcase
                end
            end
            vgar_pkg::BK_PAL_READ:
            begin
                // The registered palette entry is here; return one component.
                res_load = 1'b1;
                if (rcomp_reg == vgar_pkg::COMP_RED)
                begin
                    res_data   = pal_entry[23:16];
                    rcomp_next = vgar_pkg::COMP_GREEN;
                end
                else if (rcomp_reg == vgar_pkg::COMP_GREEN)
                begin
                    res_data   = pal_entry[15:8];
                    rcomp_next = vgar_pkg::COMP_BLUE;
                end
                else
                begin
                    res_data      = pal_entry[7:0];
                    rcomp_next    = vgar_pkg::COMP_RED;
                    pal_ridx_next = pal_ridx_reg + 8'd1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.port_decoded = out_decoded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vgar_pkg::BK_IDLE;
            pixel_mask_reg  <= 8'hff;
            aux_dac_reg     <= 8'h00;
            mask_count_reg  <= 3'd0;
            pal_ridx_reg    <= 8'h00;
            pal_widx_reg    <= 8'h00;
            rcomp_reg       <= vgar_pkg::COMP_RED;
            wcomp_reg       <= vgar_pkg::COMP_RED;
            color_latch_reg <= 16'h0000;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_mask_reg  <= pixel_mask_next;
            aux_dac_reg     <= aux_dac_next;
            mask_count_reg  <= mask_count_next;
            pal_ridx_reg    <= pal_ridx_next;
            pal_widx_reg    <= pal_widx_next;
            rcomp_reg       <= rcomp_next;
            wcomp_reg       <= wcomp_next;
            color_latch_reg <= color_latch_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg    <= res_data;
            out_decoded_reg <= res_decoded;
        end
    end

    // Palette valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                pal_valid_reg[i] <= 1'b0;
            end
            pal_hit_reg <= 1'b0;
        end
        else
        begin
            if (pal_we)
            begin
                pal_valid_reg[pal_widx_reg[PW-1:0]] <= 1'b1;
            end
            pal_hit_reg <= pal_rd_in_range && pal_valid_reg[pal_ridx_reg[PW-1:0]];
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_widx_reg[PW-1:0]] <= pal_wdata;
        end
        pal_rdata_reg <= pal_mem[pal_ridx_reg[PW-1:0]];
    end

endmodule

[rtl/core/vga_indexed_register_and_dac_port_core.sv]
// Path: an access passes the command queue and the result register; a palette data read also
// passes the registered read port. Throughput: one access per cycle while responses are taken;
// a palette data read holds the execution unit for the extra BK_PAL_READ state that this port needs.
// A two-entry command queue lets the request side keep going while a result waits.
// Reset: control registers, banks and palette valid bits clear at once; no clearing pass.
module vga_indexed_register_and_dac_port_core #(
    parameter int CRT_REG_COUNT   = vgar_pkg::CRT_REG_COUNT_DEF,
    parameter int GFX_REG_COUNT   = vgar_pkg::GFX_REG_COUNT_DEF,
    parameter int SEQ_REG_COUNT   = vgar_pkg::SEQ_REG_COUNT_DEF,
    parameter int PALETTE_ENTRIES = vgar_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vgar_req_if.sink    req,
    vgar_rsp_if.source  rsp
);

    logic           push_valid, push_ready;
    vgar_pkg::cmd_t push_cmd;
    logic           pop_valid, pop_ready;
    vgar_pkg::cmd_t pop_cmd;

    // Decode and accept.
    vgar_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Command queue.
    vgar_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Execute and respond.
    vgar_back #(
        .CRT_REG_COUNT   (CRT_REG_COUNT),
        .GFX_REG_COUNT   (GFX_REG_COUNT),
        .SEQ_REG_COUNT   (SEQ_REG_COUNT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule
